>>> src/brq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_pkg: shared types and constants of the buffer ring queue manager
// request and status codes, slot memory command, ring position helpers
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam int MAX_BUFFERS = 32;
  localparam int POS_W       = 5;
  localparam int BUF_W       = 5;
  localparam int CNT_W       = 6;
  localparam int MASK_W      = 32;

  typedef enum logic [3:0] {
    REQ_DEQUEUE       = 4'd0,
    REQ_QUEUE         = 4'd1,
    REQ_CANCEL        = 4'd2,
    REQ_LOCK          = 4'd3,
    REQ_RETIRE        = 4'd4,
    REQ_REALLOC_ALL   = 4'd5,
    REQ_REALLOC_EXCPT = 4'd6,
    REQ_NEED_NEW      = 4'd7,
    REQ_INIT          = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WOULD_BLOCK = 2'd1,
    ST_EMPTY       = 2'd2
  } rsp_status_t;

  // slot memory access, one read and one write per cycle
  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [BUF_W-1:0] wr_data;
    logic             clear;
  } slot_cmd_t;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // positions are already below n here
  function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] n);
    pos_next = (p == n - 1'b1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] pos_prev(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] n);
    pos_prev = (p == '0) ? n - 1'b1 : p - 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

endpackage

>>> src/brq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_if: channel interfaces of the buffer ring queue manager
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface brq_req_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  req_type;
  logic [brq_pkg::BUF_W-1:0]   buf_req;

  modport source (output valid, req_type, buf_req, input ready);
  modport sink   (input valid, req_type, buf_req, output ready);
endinterface

interface brq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [brq_pkg::BUF_W-1:0]   buf_out;
  logic                        flag;

  modport source (output valid, status, buf_out, flag, input ready);
  modport sink   (input valid, status, buf_out, flag, output ready);
endinterface

interface brq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [brq_pkg::POS_W-1:0]   buffer_count;

  modport source (output valid, buffer_count, input ready);
  modport sink   (input valid, buffer_count, output ready);
endinterface

>>> src/brq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_ram: generic single-port-write, single-port-read synchronous ram
// registered read data
// ----------------------------------------------------------------------------
module brq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/brq_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_slot_store: ring slot table
// ram plus per-entry valid bits; an unwritten entry reads as its own index
// ----------------------------------------------------------------------------
module brq_slot_store (
  input  logic                      clk,
  input  logic                      rst,
  input  brq_pkg::slot_cmd_t        cmd,
  output logic [brq_pkg::BUF_W-1:0] rd_data
);

  logic [brq_pkg::MAX_BUFFERS-1:0] valid;
  logic                            rd_valid;
  logic [brq_pkg::POS_W-1:0]       rd_addr_q;
  logic [brq_pkg::BUF_W-1:0]       ram_q;

  brq_ram #(
    .DEPTH (brq_pkg::MAX_BUFFERS),
    .WIDTH (brq_pkg::BUF_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (cmd.wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (ram_q)
  );

  // valid bits: cleared at once on reset or ring init
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[cmd.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid  <= valid[cmd.rd_addr];
      rd_addr_q <= cmd.rd_addr;
    end
  end

  assign rd_data = rd_valid ? ram_q : rd_addr_q;

endmodule

>>> src/buffer_ring_queue_manager_core.sv
`timescale 1ns / 1ps
// result: positions outside the ring are reduced by n, one step at a time (at most 15),
//   then the slot memory is read and execute registers the result, waiting on rsp.ready
// requests: a new one is accepted only once the last has left execute, after a pass
//   through the slot memory (reduce/read, execute/write, accept)
// reset: synchronous; counters, positions and mask take their values for buffer_count 2,
//   the slot table returns to identity through valid bits (no clearing pass)
// ----------------------------------------------------------------------------
// buffer_ring_queue_manager_core: producer/consumer buffer ring manager
// dequeue, queue, cancel, lock check, retire, reallocation mask and init
// ----------------------------------------------------------------------------
module buffer_ring_queue_manager_core (
  input  logic             clk,
  input  logic             rst,
  brq_req_if.sink          req,
  brq_rsp_if.source        rsp,
  brq_cfg_if.sink          cfg
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REDUCE = 3'b010,
    S_EXEC   = 3'b100
  } state_t;

  state_t state;

  // ring registers
  logic [brq_pkg::POS_W-1:0]  buffer_count;
  logic [brq_pkg::POS_W-1:0]  head_pos;
  logic [brq_pkg::POS_W-1:0]  tail_pos;
  logic [brq_pkg::POS_W-1:0]  last_queued_pos;
  logic [brq_pkg::CNT_W-1:0]  free_count;
  logic [brq_pkg::CNT_W-1:0]  pending_count;
  logic [brq_pkg::MASK_W-1:0] realloc_bits;

  // latched transaction and working copies of positions reduced modulo n
  logic [3:0]                 req_q;
  logic [brq_pkg::BUF_W-1:0]  buf_q;
  logic [brq_pkg::POS_W-1:0]  hp_w;
  logic [brq_pkg::POS_W-1:0]  tp_w;
  logic [brq_pkg::POS_W-1:0]  lp_w;

  // output register, parts the response side from the request side
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic [brq_pkg::BUF_W-1:0]  out_buf;
  logic                       out_flag;

  logic [brq_pkg::POS_W-1:0]  n;
  logic                       all_in;
  logic                       go;
  logic [brq_pkg::MASK_W-1:0] all_mask;
  logic [brq_pkg::MASK_W-1:0] buf_bit;
  logic [brq_pkg::BUF_W-1:0]  slot_rd;
  brq_pkg::slot_cmd_t         slot_cmd;

  // ring size, clamped to 2 .. MAX_BUFFERS-1
  always_comb begin
    if (buffer_count < 5'd2) begin
      n = 5'd2;
    end else if (buffer_count > 5'(brq_pkg::MAX_BUFFERS - 1)) begin
      n = 5'(brq_pkg::MAX_BUFFERS - 1);
    end else begin
      n = buffer_count;
    end
  end

  assign all_in   = (hp_w < n) && (tp_w < n) && (lp_w < n);
  assign go       = !out_valid || rsp.ready;
  // buffer b owns bit 31-b
  assign all_mask = ~({brq_pkg::MASK_W{1'b1}} >> n);
  assign buf_bit  = {1'b1, {(brq_pkg::MASK_W-1){1'b0}}} >> buf_q;

  // config channel, always ready; the user must write it only while idle, the block does not enforce this
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count <= 5'd2;
    end else if (cfg.valid) begin
      buffer_count <= cfg.buffer_count;
    end
  end

  assign req.ready = (state == S_IDLE);

  // slot memory: read issued when reduction is done, write in execute
  // reads and writes never share a cycle, so no forwarding is needed
  always_comb begin
    slot_cmd         = '0;
    slot_cmd.rd_en   = (state == S_REDUCE) && all_in;
    slot_cmd.wr_data = buf_q;
    if (req_q == brq_pkg::REQ_RETIRE) begin
      slot_cmd.rd_addr = brq_pkg::pos_next(hp_w, n);
    end else if (req_q == brq_pkg::REQ_LOCK) begin
      slot_cmd.rd_addr = hp_w;
    end else begin
      slot_cmd.rd_addr = tp_w;
    end
    if (req_q == brq_pkg::REQ_QUEUE) begin
      slot_cmd.wr_addr = brq_pkg::pos_next(lp_w, n);
    end else begin
      slot_cmd.wr_addr = brq_pkg::pos_prev(tp_w, n);
    end
    if ((state == S_EXEC) && go) begin
      slot_cmd.wr_en = (req_q == brq_pkg::REQ_QUEUE) || (req_q == brq_pkg::REQ_CANCEL);
      slot_cmd.clear = (req_q == brq_pkg::REQ_INIT);
    end
  end

  brq_slot_store u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (slot_cmd),
    .rd_data (slot_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (all_in) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // transaction capture and one subtraction step per cycle on out-of-ring positions
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req.valid) begin
      req_q <= req.req_type;
      buf_q <= req.buf_req;
      hp_w  <= head_pos;
      tp_w  <= tail_pos;
      lp_w  <= last_queued_pos;
    end else if (state == S_REDUCE) begin
      if (hp_w >= n) begin
        hp_w <= hp_w - n;
      end
      if (tp_w >= n) begin
        tp_w <= tp_w - n;
      end
      if (lp_w >= n) begin
        lp_w <= lp_w - n;
      end
    end
  end

  // request execution and ring state update
  always_ff @(posedge clk) begin
    if (rst) begin
      head_pos        <= 5'd1;
      tail_pos        <= '0;
      last_queued_pos <= 5'd1;
      free_count      <= 6'd2;
      pending_count   <= '0;
      realloc_bits    <= '0;
    end else if ((state == S_EXEC) && go) begin
      unique case (req_q)
        brq_pkg::REQ_DEQUEUE: begin
          if (free_count != '0) begin
            free_count <= free_count - 1'b1;
            tail_pos   <= brq_pkg::pos_next(tp_w, n);
          end
        end
        brq_pkg::REQ_QUEUE: begin
          last_queued_pos <= brq_pkg::pos_next(lp_w, n);
          pending_count   <= brq_pkg::sat_inc(pending_count);
        end
        brq_pkg::REQ_CANCEL: begin
          tail_pos   <= brq_pkg::pos_prev(tp_w, n);
          free_count <= brq_pkg::sat_inc(free_count);
        end
        brq_pkg::REQ_RETIRE: begin
          if (pending_count != '0) begin
            pending_count <= pending_count - 1'b1;
            head_pos      <= brq_pkg::pos_next(hp_w, n);
            free_count    <= brq_pkg::sat_inc(free_count);
          end
        end
        brq_pkg::REQ_REALLOC_ALL: begin
          realloc_bits <= realloc_bits | all_mask;
        end
        brq_pkg::REQ_REALLOC_EXCPT: begin
          // the named buffer is spared only when it lies inside the ring
          if (buf_q < n) begin
            realloc_bits <= realloc_bits | (all_mask & ~buf_bit);
          end else begin
            realloc_bits <= realloc_bits | all_mask;
          end
        end
        brq_pkg::REQ_NEED_NEW: begin
          realloc_bits <= realloc_bits & ~buf_bit;
        end
        brq_pkg::REQ_INIT: begin
          head_pos        <= n - 1'b1;
          tail_pos        <= '0;
          last_queued_pos <= n - 1'b1;
          free_count      <= {1'b0, n};
          pending_count   <= '0;
          realloc_bits    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EXEC) && go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EXEC) && go) begin
      out_status <= brq_pkg::ST_OK;
      out_buf    <= '0;
      out_flag   <= 1'b0;
      unique case (req_q)
        brq_pkg::REQ_DEQUEUE: begin
          if (free_count == '0) begin
            out_status <= brq_pkg::ST_WOULD_BLOCK;
          end else begin
            out_buf <= slot_rd;
          end
        end
        brq_pkg::REQ_LOCK: begin
          // would block while the buffer is still at the head
          out_flag <= (buf_q != slot_rd);
          if (buf_q == slot_rd) begin
            out_status <= brq_pkg::ST_WOULD_BLOCK;
          end
        end
        brq_pkg::REQ_RETIRE: begin
          if (pending_count == '0) begin
            out_status <= brq_pkg::ST_EMPTY;
          end else begin
            out_buf <= slot_rd;
          end
        end
        brq_pkg::REQ_NEED_NEW: begin
          out_flag <= |(realloc_bits & buf_bit);
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.buf_out = out_buf;
  assign rsp.flag    = out_flag;

  // positions used in execute are inside the ring
  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> ((hp_w < n) && (tp_w < n) && (lp_w < n)))
    else $error("ring position outside ring in execute");

  // slot memory never read and written in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(slot_cmd.rd_en && slot_cmd.wr_en))
    else $error("slot memory read and write overlap");

  // a response appears only after an execute cycle
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("response without execute");

  // execute always follows a slot read
  a_exec_after_read: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && !$past(state == S_EXEC)) |-> $past(slot_cmd.rd_en))
    else $error("execute without slot read");

endmodule
